// File: hdl/dbnc_pkg.sv
// Shared types and constants for the discrete input debouncer.
// Holds the channel and window sizes, the board pin table and the window result type.
// No dependencies.
package dbnc_pkg;

    localparam int CHANNELS = 32;
    localparam int WINDOW = 4;
    localparam int CNT_W = $clog2(WINDOW);
    localparam int VEC_W = 32;
    localparam int ID_W = 5;
    localparam int PIN_W = 5;
    localparam int PIN_COUNT = 32;

    localparam logic [VEC_W-1:0] MASK_RESET = 32'hF0FF_FFFF;

    typedef logic [PIN_W-1:0] t_pin;

    localparam t_pin PIN_TABLE [PIN_COUNT] = '{
        5'h1F, 5'h1E, 5'h1D, 5'h1C, 5'h1A, 5'h19, 5'h1B, 5'h18,
        5'h02, 5'h03, 5'h04, 5'h16, 5'h10, 5'h00, 5'h15, 5'h0A,
        5'h0B, 5'h0C, 5'h0D, 5'h0E, 5'h0F, 5'h11, 5'h12, 5'h13,
        5'h01, 5'h06, 5'h06, 5'h06, 5'h06, 5'h06, 5'h06, 5'h06
    };

    typedef struct packed {
        logic             window_done;
        logic             ignition_on;
        logic [VEC_W-1:0] input_vector;
    } t_win_result;

endpackage

// File: hdl/dbnc_if.sv
// Handshake channel interfaces for the discrete input debouncer.
// Depends on dbnc_pkg for the field widths.
interface dbnc_scan_if;
    logic                         valid;
    logic                         ready;
    logic [dbnc_pkg::VEC_W-1:0]   scan_bits;
    logic                         ignition_sample;
    logic [dbnc_pkg::ID_W-1:0]    query_id;

    modport source (output valid, output scan_bits, output ignition_sample,
                    output query_id, input ready);
    modport sink (input valid, input scan_bits, input ignition_sample,
                  input query_id, output ready);
endinterface

interface dbnc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         query_status;
    logic                         ignition_on;
    logic [dbnc_pkg::VEC_W-1:0]   input_vector;
    logic                         window_done;

    modport source (output valid, output query_status, output ignition_on,
                    output input_vector, output window_done, input ready);
    modport sink (input valid, input query_status, input ignition_on,
                  input input_vector, input window_done, output ready);
endinterface

interface dbnc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dbnc_pkg::VEC_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/dbnc_filter.sv
// Sample histories, window counter and debounced state of the debouncer.
// Produces the post-update window result for the scan being transferred.
// Depends on dbnc_pkg.
module dbnc_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [dbnc_pkg::VEC_W-1:0]   i_scan_bits,
    input  logic                         i_ignition_sample,
    input  logic [dbnc_pkg::VEC_W-1:0]   i_mask,
    output dbnc_pkg::t_win_result        o_result
);
    import dbnc_pkg::*;

    logic [WINDOW-1:0]   r_chan_hist [CHANNELS];
    logic [WINDOW-1:0]   n_chan_hist [CHANNELS];
    logic [WINDOW-1:0]   r_ign_hist;
    logic [WINDOW-1:0]   n_ign_hist;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CHANNELS-1:0] r_debounced;
    logic [CHANNELS-1:0] n_debounced;
    logic                r_ign_state;
    logic                n_ign_state;
    logic [VEC_W-1:0]    r_reported;
    logic [VEC_W-1:0]    n_reported;
    logic                n_done;

    always_comb begin
        n_done = (r_count == CNT_W'(WINDOW - 1));
        n_count = n_done ? '0 : r_count + CNT_W'(1);
        n_ign_hist = {r_ign_hist[WINDOW-2:0], i_ignition_sample};
        n_debounced = r_debounced;
        n_ign_state = r_ign_state;
        for (int i = 0; i < CHANNELS; i++) begin
            n_chan_hist[i] = {r_chan_hist[i][WINDOW-2:0], i_scan_bits[i]};
            if (n_done && (n_chan_hist[i] == '0)) begin
                n_debounced[i] = 1'b0;
            end else if (n_done && (n_chan_hist[i] == '1)) begin
                n_debounced[i] = 1'b1;
            end
        end
        if (n_done && (n_ign_hist == '0)) begin
            n_ign_state = 1'b0;
        end else if (n_done && (n_ign_hist == '1)) begin
            n_ign_state = 1'b1;
        end
        n_reported = r_reported;
        if (n_done) begin
            n_reported = n_ign_state ? VEC_W'(n_debounced) : i_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_chan_hist[i] <= '0;
            end
            r_ign_hist  <= '0;
            r_count     <= '0;
            r_debounced <= '0;
            r_ign_state <= 1'b0;
            r_reported  <= MASK_RESET;
        end else if (i_accept) begin
            r_chan_hist <= n_chan_hist;
            r_ign_hist  <= n_ign_hist;
            r_count     <= n_count;
            r_debounced <= n_debounced;
            r_ign_state <= n_ign_state;
            r_reported  <= n_reported;
        end
    end

    assign o_result.window_done  = n_done;
    assign o_result.ignition_on  = n_ign_state;
    assign o_result.input_vector = n_reported;

`ifndef SYNTHESIS
    a_window_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && n_done |=> r_count == '0)
        else $error("window counter did not wrap at window end");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_debounced) && $stable(r_ign_state) && $stable(r_count))
        else $error("debounce state changed without a scan transfer");

    a_mid_window_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !n_done |=> $stable(r_reported) && $stable(r_debounced))
        else $error("reported vector changed inside a window");
`endif

endmodule

// File: hdl/discrete_input_debouncer_unit.sv
// Top level of the discrete input debouncer: scan, result and mask channels,
// mask register, pin table query and the result register.
// Depends on dbnc_pkg, the channel interfaces and dbnc_filter.
//
// Each transfer on the scan channel carries one sample of every channel, one
// ignition sample and a query id. Every scan produces exactly one result.
// Scans are grouped into windows of four; on the fourth scan each channel whose
// four samples agree takes that value, and ignition is debounced the same way.
// The result shows the state after this scan: the reported vector (debounced
// vector with ignition on, otherwise the polarity mask), the debounced ignition,
// a window end flag, and the queried bit XOR the mask bit at its board pin.
// Result valid rises in the cycle after the scan transfer. One scan is taken
// every cycle; the rate is set by the single result register, which frees as it
// is read. When the receiver stalls, the result holds and the scan channel
// stays ready only while the result register is free or being read.
// The mask channel is always ready and must only be written while idle.
// Reset clears all histories, the debounced state and ignition, and loads the
// mask and reported vector with 0xF0FFFFFF.
module discrete_input_debouncer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dbnc_scan_if.sink    i_scan,
    dbnc_cfg_if.sink     i_cfg,
    dbnc_result_if.source o_result
);
    import dbnc_pkg::*;

    logic [VEC_W-1:0] r_mask;
    logic             r_out_valid;
    logic             r_out_status;
    logic             r_out_ign;
    logic [VEC_W-1:0] r_out_vector;
    logic             r_out_done;
    logic             n_status;
    logic             scan_xfer;
    t_pin             pin;
    t_win_result      win;

    assign i_cfg.ready = 1'b1;
    assign i_scan.ready = !r_out_valid || o_result.ready;
    assign scan_xfer = i_scan.valid && i_scan.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (i_cfg.valid) begin
            r_mask <= i_cfg.data;
        end
    end

    dbnc_filter u_filter (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (scan_xfer),
        .i_scan_bits       (i_scan.scan_bits),
        .i_ignition_sample (i_scan.ignition_sample),
        .i_mask            (r_mask),
        .o_result          (win)
    );

    always_comb begin
        pin = PIN_TABLE[i_scan.query_id];
        n_status = win.input_vector[pin] ^ r_mask[pin];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (scan_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_xfer) begin
            r_out_status <= n_status;
            r_out_ign    <= win.ignition_on;
            r_out_vector <= win.input_vector;
            r_out_done   <= win.window_done;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.query_status = r_out_status;
    assign o_result.ignition_on  = r_out_ign;
    assign o_result.input_vector = r_out_vector;
    assign o_result.window_done  = r_out_done;

`ifndef SYNTHESIS
    a_free_means_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_scan.ready)
        else $error("scan channel stalled with an empty result register");

    a_ign_off_shows_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done && !r_out_ign |-> r_out_vector == r_mask)
        else $error("window end with ignition off did not report the mask");
`endif

endmodule

// File: verif/tb_discrete_input_debouncer_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for discrete_input_debouncer_unit with scan, result and mask channels.
// Depends on dbnc_pkg and the channel interfaces in hdl/dbnc_if.sv.
module tb_discrete_input_debouncer_unit;
    import dbnc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_WINDOWS = 125;

    typedef struct {
        logic [VEC_W-1:0] scan_bits;
        logic             ign;
        logic [ID_W-1:0]  qid;
    } t_scan;

    typedef struct {
        logic             status;
        logic             ign_on;
        logic [VEC_W-1:0] vec;
        logic             done;
    } t_status;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dbnc_scan_if   scan_ch ();
    dbnc_cfg_if    cfg_ch ();
    dbnc_result_if result_ch ();

    discrete_input_debouncer_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scan   (scan_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    always #4 i_clk = ~i_clk;

    // Debouncer state mirrored by the predictor.
    logic [3:0]       chan_hist [CHANNELS];
    logic [3:0]       ign_hist;
    logic [CNT_W-1:0] scan_cnt;
    logic [VEC_W-1:0] deb_vec;
    logic             ign_state;
    logic [VEC_W-1:0] rep_vec;
    logic [VEC_W-1:0] pol_mask;

    t_scan   pending_scans [$];
    t_status expected_results [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit scan_xfer = 1'b0;
    int mismatches = 0;
    int scans_taken = 0;
    int results_seen = 0;
    int window_ends = 0;
    int mask_writes = 0;
    int quiet_cycles = 0;

    logic [VEC_W-1:0] walk_base;
    logic             walk_ign;

    function automatic logic [PIN_W-1:0] board_pin(input logic [ID_W-1:0] qid);
        case (qid)
            5'd0:  board_pin = 5'h1F;
            5'd1:  board_pin = 5'h1E;
            5'd2:  board_pin = 5'h1D;
            5'd3:  board_pin = 5'h1C;
            5'd4:  board_pin = 5'h1A;
            5'd5:  board_pin = 5'h19;
            5'd6:  board_pin = 5'h1B;
            5'd7:  board_pin = 5'h18;
            5'd8:  board_pin = 5'h02;
            5'd9:  board_pin = 5'h03;
            5'd10: board_pin = 5'h04;
            5'd11: board_pin = 5'h16;
            5'd12: board_pin = 5'h10;
            5'd13: board_pin = 5'h00;
            5'd14: board_pin = 5'h15;
            5'd15: board_pin = 5'h0A;
            5'd16: board_pin = 5'h0B;
            5'd17: board_pin = 5'h0C;
            5'd18: board_pin = 5'h0D;
            5'd19: board_pin = 5'h0E;
            5'd20: board_pin = 5'h0F;
            5'd21: board_pin = 5'h11;
            5'd22: board_pin = 5'h12;
            5'd23: board_pin = 5'h13;
            5'd24: board_pin = 5'h01;
            default: board_pin = 5'h06;
        endcase
    endfunction

    function automatic void clear_debouncer();
        for (int c = 0; c < CHANNELS; c++) begin
            chan_hist[c] = 4'h0;
        end
        ign_hist = 4'h0;
        scan_cnt = '0;
        deb_vec = '0;
        ign_state = 1'b0;
        rep_vec = MASK_RESET;
        pol_mask = MASK_RESET;
    endfunction

    function automatic t_status debounce_scan(input t_scan s);
        t_status r;
        logic [PIN_W-1:0] pin;
        for (int c = 0; c < CHANNELS; c++) begin
            chan_hist[c] = {chan_hist[c][2:0], s.scan_bits[c]};
        end
        ign_hist = {ign_hist[2:0], s.ign};
        r.done = 1'b0;
        if (scan_cnt == CNT_W'(WINDOW - 1)) begin
            scan_cnt = '0;
            r.done = 1'b1;
            window_ends++;
            for (int c = 0; c < CHANNELS; c++) begin
                if (chan_hist[c] == 4'h0) begin
                    deb_vec[c] = 1'b0;
                end else if (chan_hist[c] == 4'hF) begin
                    deb_vec[c] = 1'b1;
                end
            end
            if (ign_hist == 4'h0) begin
                ign_state = 1'b0;
            end else if (ign_hist == 4'hF) begin
                ign_state = 1'b1;
            end
            rep_vec = ign_state ? deb_vec : pol_mask;
        end else begin
            scan_cnt = scan_cnt + CNT_W'(1);
        end
        pin = board_pin(s.qid);
        r.status = rep_vec[pin] ^ pol_mask[pin];
        r.ign_on = ign_state;
        r.vec = rep_vec;
        return r;
    endfunction

    function automatic void queue_scan(input logic [VEC_W-1:0] bits, input logic ign,
                                       input logic [ID_W-1:0] qid);
        t_scan s;
        s.scan_bits = bits;
        s.ign = ign;
        s.qid = qid;
        pending_scans.push_back(s);
    endfunction

    function automatic void note_mismatch(input string what, input logic [VEC_W-1:0] exp_v,
                                          input logic [VEC_W-1:0] act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s mismatch on result %0d: expected %h, got %h",
                     $realtime, what, results_seen, exp_v, act_v);
        end
    endfunction

    // Windows of four scans: mostly settled channels with some chatter, a steady
    // ignition level that changes now and then, and a share of pure noise.
    function automatic void queue_random_windows(input int count);
        logic [VEC_W-1:0] chatter;
        logic             noisy;
        for (int w = 0; w < count; w++) begin
            noisy = ($urandom_range(9) == 0);
            if ($urandom_range(3) == 0) begin
                walk_base = $urandom;
            end else begin
                walk_base = walk_base ^ ($urandom & $urandom & $urandom);
            end
            if ($urandom_range(4) == 0) begin
                walk_ign = ~walk_ign;
            end
            chatter = ($urandom_range(2) == 0) ? ($urandom & $urandom & $urandom) : '0;
            for (int k = 0; k < WINDOW; k++) begin
                if (noisy) begin
                    queue_scan($urandom, 1'($urandom_range(1)), 5'($urandom_range(31)));
                end else begin
                    queue_scan(walk_base ^ (chatter & $urandom),
                               ($urandom_range(11) == 0) ? ~walk_ign : walk_ign,
                               5'($urandom_range(31)));
                end
            end
        end
    endfunction

    task automatic write_mask(input logic [VEC_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_scans.size() != 0 || scan_ch.valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    // Scan driver: holds an item until its transfer, then loads the next one.
    always @(negedge i_clk) begin
        t_scan s;
        if (!i_rst_n) begin
            scan_ch.valid <= 1'b0;
        end else if (!scan_ch.valid || scan_xfer) begin
            if (pending_scans.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s = pending_scans.pop_front();
                scan_ch.valid <= 1'b1;
                scan_ch.scan_bits <= s.scan_bits;
                scan_ch.ignition_sample <= s.ign;
                scan_ch.query_id <= s.qid;
            end else begin
                scan_ch.valid <= 1'b0;
            end
        end
        scan_xfer = 1'b0;
    end

    always @(negedge i_clk) begin
        result_ch.ready <= i_rst_n && ($urandom_range(99) >= snk_idle_pct);
    end

    // Monitor: predicts on scan and mask transfers, checks result transfers.
    always @(posedge i_clk) begin
        t_scan   s;
        t_status e;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (scan_ch.valid && scan_ch.ready) begin
                s.scan_bits = scan_ch.scan_bits;
                s.ign = scan_ch.ignition_sample;
                s.qid = scan_ch.query_id;
                expected_results.push_back(debounce_scan(s));
                scans_taken++;
                scan_xfer = 1'b1;
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                pol_mask = cfg_ch.data;
                mask_writes++;
                moved = 1'b1;
            end
            if (result_ch.valid && result_ch.ready) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result", '0, result_ch.input_vector);
                end else begin
                    e = expected_results.pop_front();
                    if (result_ch.query_status !== e.status) begin
                        note_mismatch("query_status", VEC_W'(e.status),
                                      VEC_W'(result_ch.query_status));
                    end
                    if (result_ch.ignition_on !== e.ign_on) begin
                        note_mismatch("ignition_on", VEC_W'(e.ign_on),
                                      VEC_W'(result_ch.ignition_on));
                    end
                    if (result_ch.input_vector !== e.vec) begin
                        note_mismatch("input_vector", e.vec, result_ch.input_vector);
                    end
                    if (result_ch.window_done !== e.done) begin
                        note_mismatch("window_done", VEC_W'(e.done),
                                      VEC_W'(result_ch.window_done));
                    end
                end
                results_seen++;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        scan_ch.valid = 1'b0;
        scan_ch.scan_bits = '0;
        scan_ch.ignition_sample = 1'b0;
        scan_ch.query_id = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        result_ch.ready = 1'b0;
        clear_debouncer();
        walk_base = $urandom;
        walk_ign = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 18;
        snk_idle_pct = 54;

        // Ignition and all channels come on together.
        for (int k = 0; k < 4; k++) queue_scan('1, 1'b1, 5'(8 + k));
        // One chattering scan: the lower half keeps its old level, ignition stays on.
        queue_scan('0, 1'b1, 5'd12);
        queue_scan(32'h0000_FFFF, 1'b0, 5'd13);
        queue_scan('0, 1'b1, 5'd14);
        queue_scan('0, 1'b1, 5'd15);
        // Ignition goes off, so the mask is reported.
        for (int k = 0; k < 4; k++) queue_scan(32'hA5A5_A5A5, 1'b0, 5'(16 + k));
        // Ignition back on with an alternating pattern, then the repeated board pins.
        for (int k = 0; k < 4; k++) queue_scan(32'h5A5A_5A5A, 1'b1, 5'(20 + k));
        for (int k = 0; k < 8; k++) queue_scan(32'hFFFF_FFBF ^ (k[0] ? 32'h40 : 32'h0),
                                               1'b1, 5'(24 + k));
        wait_idle();

        write_mask('0);
        queue_random_windows(RANDOM_WINDOWS);
        wait_idle();

        src_idle_pct = 54;
        snk_idle_pct = 18;
        write_mask('1);
        queue_random_windows(RANDOM_WINDOWS);
        wait_idle();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_mask($urandom);
        queue_random_windows(RANDOM_WINDOWS / 2);
        wait_idle();
        write_mask(MASK_RESET);
        queue_random_windows(RANDOM_WINDOWS / 2);
        wait_idle();

        $display("Ran %0d scans through %0d debounce windows under %0d mask settings,",
                 scans_taken, window_ends, mask_writes);
        $display("checked %0d results and found %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
